>>> hw/rtl/byte_ring_fifo_defines.svh
// Assertion macros shared by the byte ring FIFO RTL.
`ifndef BYTE_RING_FIFO_DEFINES_SVH
`define BYTE_RING_FIFO_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BRF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BRF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/brf_pkg.sv
// Types and constants of the byte ring FIFO.
`default_nettype none

package brf_pkg;

  localparam int DEPTH  = 1024; // byte slots in the store
  localparam int BYTE_W = 8;   // store and data word width
  localparam int CNT_W  = 11;  // capacity, occupancy and count fields
  localparam int RUN_W  = 7;   // requested run length field

  typedef enum logic [2:0] {
    KIND_PUSH    = 3'd0,
    KIND_POP     = 3'd1,
    KIND_PEEK    = 3'd2,
    KIND_DISCARD = 3'd3,
    KIND_CLEAR   = 3'd4,
    KIND_STATUS  = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_NONE = 2'd1,
    STAT_FULL = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_t;

endpackage

`default_nettype wire

>>> hw/rtl/brf_ram.sv
// Byte store: one write port, one read port, registered read data.
`default_nettype none

module brf_ram #(
  parameter int DEPTH = 1024
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [brf_pkg::BYTE_W-1:0] wdata,
  input  logic                       re,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [brf_pkg::BYTE_W-1:0] rdata
);

  logic [brf_pkg::BYTE_W-1:0] mem [DEPTH];
  logic [brf_pkg::BYTE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> hw/rtl/byte_ring_fifo.sv
// Top level of the byte ring FIFO: command decode, index control, result words.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+---------------------------------------
//  command  | start / busy                | in_kind, in_data_byte, in_count
//  result   | out_strobe (one cycle)      | out_data_out .. out_free_slots
//  config   | cfg_valid / cfg_ready       | cfg_capacity
//
// Push, discard, clear and status answer with a single word, shown in the next cycle.
// Pop and peek hold busy while their run streams out, one byte per cycle,
// paced by the single registered read port of the store.
// Reset (rst_n low, synchronous) empties the queue and sets capacity to 1024;
// the store is not cleared. Config writes are taken while busy is low; they empty it.
// The receiver cannot stall: every result word is taken in its strobe cycle.
`default_nettype none

`include "byte_ring_fifo_defines.svh"

module byte_ring_fifo #(
  parameter int MAX_RUN = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_kind,
  input  logic [7:0]  in_data_byte,
  input  logic [6:0]  in_count,
  // result channel
  output logic        out_strobe,
  output logic [7:0]  out_data_out,
  output logic        out_data_valid,
  output logic        out_last,
  output logic [1:0]  out_status,
  output logic [10:0] out_done_count,
  output logic [10:0] out_occupancy,
  output logic [10:0] out_free_slots,
  // capacity register
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_capacity
);

  localparam int IDX_W = $clog2(brf_pkg::DEPTH);
  localparam int CW    = brf_pkg::CNT_W;
  localparam int RW    = brf_pkg::RUN_W;
  localparam int BW    = brf_pkg::BYTE_W;
  localparam logic [CW-1:0] CAP_RST =
    CW'((brf_pkg::DEPTH < 1024) ? brf_pkg::DEPTH : 1024);
  localparam logic [RW-1:0] RUN_MAX = RW'(MAX_RUN);

  // advance a ring index, wrapping at the capacity in use
  function automatic logic [IDX_W-1:0] step_idx(input logic [IDX_W-1:0] p,
                                                input logic [CW-1:0]    cap);
    logic [CW-1:0] q;
    q = CW'(p) + CW'(1);
    return (q >= cap) ? '0 : IDX_W'(q);
  endfunction

  // control state
  brf_pkg::state_t  state_r, state_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0] wr_idx_r, wr_idx_nxt;
  logic [IDX_W-1:0] rd_ptr_r, rd_ptr_nxt;   // walking read address during a run
  logic             empty_r, empty_nxt;
  logic [CW-1:0]    cap_r, cap_nxt;
  logic [RW-1:0]    run_left_r, run_left_nxt;
  logic             out_strobe_r, out_strobe_nxt;

  // result word
  logic [BW-1:0]    out_data_r, out_data_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_last_r, out_last_nxt;
  logic [1:0]       out_status_r, out_status_nxt;
  logic [CW-1:0]    out_done_r, out_done_nxt;
  logic [CW-1:0]    out_occ_r, out_occ_nxt;
  logic [CW-1:0]    out_free_r, out_free_nxt;

  // store ports
  logic             ram_we;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  logic [BW-1:0]    ram_rdata;

  // decode helpers
  logic             accept;
  logic             run_final;
  logic [CW-1:0]    rd_ext;
  logic [CW-1:0]    wr_ext;
  logic [CW-1:0]    occ;
  logic [CW-1:0]    occ_after;
  logic [RW-1:0]    cnt_sat;
  logic [RW-1:0]    run_n;
  logic [CW:0]      pop_sum;
  logic [CW:0]      pop_wrap;
  logic             is_remove;
  logic [CW-1:0]    cap_wr;

  brf_ram #(
    .DEPTH (brf_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_idx_r),
    .wdata (in_data_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy      = (state_r == brf_pkg::ST_RUN);
  assign cfg_ready = (state_r == brf_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign run_final = busy && (run_left_r == RW'(1));

  // bytes held: equal indices with the flag clear mean full
  always_comb begin
    rd_ext = CW'(rd_idx_r);
    wr_ext = CW'(wr_idx_r);
    if (empty_r) begin
      occ = '0;
    end else if (wr_ext > rd_ext) begin
      occ = wr_ext - rd_ext;
    end else begin
      occ = cap_r - (rd_ext - wr_ext);
    end
    cnt_sat   = (in_count > RUN_MAX) ? RUN_MAX : in_count;
    run_n     = (CW'(cnt_sat) < occ) ? cnt_sat : RW'(occ);
    // run_n <= occ <= cap, so one wrap at most
    pop_sum   = {1'b0, rd_ext} + (CW + 1)'(run_n);
    pop_wrap  = (pop_sum >= {1'b0, cap_r}) ? (pop_sum - {1'b0, cap_r}) : pop_sum;
    is_remove = in_kind inside {brf_pkg::KIND_POP, brf_pkg::KIND_PEEK,
                                brf_pkg::KIND_DISCARD};
    if (cfg_capacity == '0) begin
      cap_wr = CW'(1);
    end else if (32'(cfg_capacity) > brf_pkg::DEPTH) begin
      cap_wr = CW'(brf_pkg::DEPTH);
    end else begin
      cap_wr = cfg_capacity;
    end
  end

  // next state, index updates and result word
  always_comb begin
    state_nxt      = state_r;
    rd_idx_nxt     = rd_idx_r;
    wr_idx_nxt     = wr_idx_r;
    rd_ptr_nxt     = rd_ptr_r;
    empty_nxt      = empty_r;
    cap_nxt        = cap_r;
    run_left_nxt   = run_left_r;
    out_strobe_nxt = 1'b0;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;
    out_done_nxt   = out_done_r;
    out_occ_nxt    = out_occ_r;
    out_free_nxt   = out_free_r;
    occ_after      = occ;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_raddr      = rd_idx_r;

    case (state_r)
      brf_pkg::ST_IDLE: begin
        if (accept) begin
          // single-word defaults; a pop or peek run overrides data fields later
          out_strobe_nxt = 1'b1;
          out_data_nxt   = '0;
          out_valid_nxt  = 1'b0;
          out_last_nxt   = 1'b1;
          out_status_nxt = brf_pkg::STAT_OK;
          out_done_nxt   = '0;
          case (in_kind)
            brf_pkg::KIND_PUSH: begin
              if (occ >= cap_r) begin
                out_status_nxt = brf_pkg::STAT_FULL;
              end else begin
                ram_we       = 1'b1;
                wr_idx_nxt   = step_idx(wr_idx_r, cap_r);
                empty_nxt    = 1'b0;
                out_done_nxt = CW'(1);
                occ_after    = occ + CW'(1);
              end
            end
            brf_pkg::KIND_POP, brf_pkg::KIND_PEEK, brf_pkg::KIND_DISCARD: begin
              if (cnt_sat == '0 || occ == '0) begin
                out_status_nxt = brf_pkg::STAT_NONE;
              end else begin
                out_done_nxt = CW'(run_n);
                if (in_kind != brf_pkg::KIND_PEEK) begin
                  if (CW'(run_n) == occ) begin
                    rd_idx_nxt = '0;
                    wr_idx_nxt = '0;
                    empty_nxt  = 1'b1;
                    occ_after  = '0;
                  end else begin
                    rd_idx_nxt = IDX_W'(pop_wrap);
                    occ_after  = occ - CW'(run_n);
                  end
                end
                if (in_kind != brf_pkg::KIND_DISCARD) begin
                  // first byte read now, words stream out through the run state
                  out_strobe_nxt = 1'b0;
                  ram_re         = is_remove;
                  ram_raddr      = rd_idx_r;
                  rd_ptr_nxt     = step_idx(rd_idx_r, cap_r);
                  run_left_nxt   = run_n;
                  state_nxt      = brf_pkg::ST_RUN;
                end
              end
            end
            brf_pkg::KIND_CLEAR: begin
              rd_idx_nxt = '0;
              wr_idx_nxt = '0;
              empty_nxt  = 1'b1;
              occ_after  = '0;
            end
            default: begin
              // status and unused codes report only
            end
          endcase
          out_occ_nxt  = occ_after;
          out_free_nxt = cap_r - occ_after;
        end
      end
      brf_pkg::ST_RUN: begin
        // one byte out per cycle, next address read ahead
        ram_re         = 1'b1;
        ram_raddr      = rd_ptr_r;
        rd_ptr_nxt     = step_idx(rd_ptr_r, cap_r);
        out_strobe_nxt = 1'b1;
        out_data_nxt   = ram_rdata;
        out_valid_nxt  = 1'b1;
        out_last_nxt   = (run_left_r == RW'(1));
        run_left_nxt   = run_left_r - RW'(1);
        if (run_left_r == RW'(1)) begin
          state_nxt = brf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = brf_pkg::ST_IDLE;
      end
    endcase

    // capacity write empties the queue
    if (cfg_valid && cfg_ready) begin
      cap_nxt    = cap_wr;
      rd_idx_nxt = '0;
      wr_idx_nxt = '0;
      empty_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= brf_pkg::ST_IDLE;
      rd_idx_r     <= '0;
      wr_idx_r     <= '0;
      rd_ptr_r     <= '0;
      empty_r      <= 1'b1;
      cap_r        <= CAP_RST;
      run_left_r   <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rd_idx_r     <= rd_idx_nxt;
      wr_idx_r     <= wr_idx_nxt;
      rd_ptr_r     <= rd_ptr_nxt;
      empty_r      <= empty_nxt;
      cap_r        <= cap_nxt;
      run_left_r   <= run_left_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r   <= out_data_nxt;
    out_valid_r  <= out_valid_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
    out_done_r   <= out_done_nxt;
    out_occ_r    <= out_occ_nxt;
    out_free_r   <= out_free_nxt;
  end

  assign out_strobe     = out_strobe_r;
  assign out_data_out   = out_data_r;
  assign out_data_valid = out_valid_r;
  assign out_last       = out_last_r;
  assign out_status     = out_status_r;
  assign out_done_count = out_done_r;
  assign out_occupancy  = out_occ_r;
  assign out_free_slots = out_free_r;

  // an empty queue always sits at index zero
  `BRF_ASSERT_SAME(a_empty_at_zero, empty_r, {rd_idx_r, wr_idx_r} == '0, "empty off index zero")
  // a word that is not the last of its command is always followed by more
  `BRF_ASSERT_SAME(a_mid_word_busy, out_strobe_r && !out_last_r, busy, "mid-run word idle")
  // the final run cycle produces the last word
  `BRF_ASSERT_NEXT(a_run_ends_last, run_final, out_strobe_r && out_last_r, "run end lacks last")
  // every taken command either answers at once or starts a run
  `BRF_ASSERT_NEXT(a_cmd_answered, accept, out_strobe_r || busy, "command dropped")

endmodule

`default_nettype wire

>>> tb/tb_byte_ring_fifo.sv
// Self-checking testbench for the byte ring FIFO: directed and random commands.
`timescale 1ns / 100ps

module tb_byte_ring_fifo;

  localparam int STORE_DEPTH = brf_pkg::DEPTH;  // byte slots in the uut store
  localparam int RUN_LIMIT   = 64;    // matches the uut default MAX_RUN
  localparam int TAIL_CYCLES = 4;     // settle time after the last result word
  localparam int DRAIN_LIMIT = 500;   // cycles allowed for outstanding words

  // kind codes outside the enum; the block treats them as status
  localparam logic [2:0] KIND_SPARE6 = 3'd6;
  localparam logic [2:0] KIND_SPARE7 = 3'd7;

  // one result word, packed in port order
  typedef struct packed {
    logic [7:0]  data;
    logic        valid;
    logic        last;
    logic [1:0]  status;
    logic [10:0] done;
    logic [10:0] occ;
    logic [10:0] free;
  } result_t;

  // Ring queue predictor plus the list of result words still owed by the uut.
  class byte_queue_board;
    logic [7:0]  ring [STORE_DEPTH];
    int unsigned rd_idx, wr_idx, cap;
    bit          q_empty;
    result_t     owed_words[$];
    int unsigned errors, words_checked, commands, byte_reads, rejects, cap_writes;

    function new();
      cap = STORE_DEPTH;
      clear_queue();
    endfunction

    function void clear_queue();
      rd_idx  = 0;
      wr_idx  = 0;
      q_empty = 1'b1;
    endfunction

    function int unsigned held();
      if (q_empty) return 0;
      if (wr_idx > rd_idx) return wr_idx - rd_idx;
      return cap + wr_idx - rd_idx;
    endfunction

    function int unsigned step_idx(int unsigned i);
      return (i + 1 >= cap) ? 0 : i + 1;
    endfunction

    function int unsigned pending();
      return owed_words.size();
    endfunction

    function void report(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endfunction

    // occupancy and free slots reflect the state after the whole command
    function void owe_word(logic [7:0] d, logic v, logic l, brf_pkg::status_t s,
                           int unsigned n);
      result_t w;
      int unsigned occ;
      occ      = held();
      w.data   = d;
      w.valid  = v;
      w.last   = l;
      w.status = s;
      w.done   = n[10:0];
      w.occ    = occ[10:0];
      w.free   = 11'(cap - occ);
      owed_words.push_back(w);
    endfunction

    function void set_capacity(logic [10:0] v);
      int unsigned c;
      c = v;
      if (c < 1) c = 1;
      if (c > STORE_DEPTH) c = STORE_DEPTH;
      cap = c;
      clear_queue();
      cap_writes++;
    endfunction

    function void predict_command(logic [2:0] kind, logic [7:0] b, logic [6:0] cnt_in);
      int unsigned cnt, occ, n, idx;
      logic [7:0]  run [$];
      cnt = cnt_in;
      if (cnt > RUN_LIMIT) cnt = RUN_LIMIT;
      occ = held();
      commands++;
      case (kind)
        brf_pkg::KIND_PUSH: begin
          if (occ >= cap) begin
            owe_word(8'h00, 1'b0, 1'b1, brf_pkg::STAT_FULL, 0);
            rejects++;
          end else begin
            ring[wr_idx] = b;
            wr_idx  = step_idx(wr_idx);
            q_empty = 1'b0;
            owe_word(8'h00, 1'b0, 1'b1, brf_pkg::STAT_OK, 1);
          end
        end
        brf_pkg::KIND_POP, brf_pkg::KIND_PEEK, brf_pkg::KIND_DISCARD: begin
          if (cnt == 0 || occ == 0) begin
            owe_word(8'h00, 1'b0, 1'b1, brf_pkg::STAT_NONE, 0);
          end else begin
            n   = (cnt < occ) ? cnt : occ;
            idx = rd_idx;
            for (int i = 0; i < n; i++) begin
              run.push_back(ring[idx]);
              idx = step_idx(idx);
            end
            if (kind != brf_pkg::KIND_PEEK) begin
              if (n == occ) clear_queue();
              else rd_idx = idx;
            end
            if (kind == brf_pkg::KIND_DISCARD) begin
              owe_word(8'h00, 1'b0, 1'b1, brf_pkg::STAT_OK, n);
            end else begin
              for (int i = 0; i < n; i++)
                owe_word(run[i], 1'b1, (i + 1 == n), brf_pkg::STAT_OK, n);
              byte_reads += n;
            end
          end
        end
        brf_pkg::KIND_CLEAR: begin
          clear_queue();
          owe_word(8'h00, 1'b0, 1'b1, brf_pkg::STAT_OK, 0);
        end
        default: begin
          owe_word(8'h00, 1'b0, 1'b1, brf_pkg::STAT_OK, 0);
        end
      endcase
    endfunction

    function void check_word(result_t got);
      result_t exp_w;
      if (owed_words.size() == 0) begin
        report($sformatf("unexpected result word %h", got));
        return;
      end
      exp_w = owed_words.pop_front();
      words_checked++;
      if (got.data !== exp_w.data)
        report($sformatf("data_out %h, want %h", got.data, exp_w.data));
      if (got.valid !== exp_w.valid)
        report($sformatf("data_valid %b, want %b", got.valid, exp_w.valid));
      if (got.last !== exp_w.last)
        report($sformatf("last %b, want %b", got.last, exp_w.last));
      if (got.status !== exp_w.status)
        report($sformatf("status %0d, want %0d", got.status, exp_w.status));
      if (got.done !== exp_w.done)
        report($sformatf("done_count %0d, want %0d", got.done, exp_w.done));
      if (got.occ !== exp_w.occ)
        report($sformatf("occupancy %0d, want %0d", got.occ, exp_w.occ));
      if (got.free !== exp_w.free)
        report($sformatf("free slots %0d, want %0d", got.free, exp_w.free));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_kind = brf_pkg::KIND_STATUS;
  logic [7:0]  in_data_byte = 8'h00;
  logic [6:0]  in_count = 7'd0;
  logic        out_strobe;
  logic [7:0]  out_data_out;
  logic        out_data_valid;
  logic        out_last;
  logic [1:0]  out_status;
  logic [10:0] out_done_count;
  logic [10:0] out_occupancy;
  logic [10:0] out_free_slots;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [10:0] cfg_capacity = 11'd0;

  byte_queue_board board = new();
  int          sender_idle_pct = 0;

  byte_ring_fifo uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_kind        (in_kind),
    .in_data_byte   (in_data_byte),
    .in_count       (in_count),
    .out_strobe     (out_strobe),
    .out_data_out   (out_data_out),
    .out_data_valid (out_data_valid),
    .out_last       (out_last),
    .out_status     (out_status),
    .out_done_count (out_done_count),
    .out_occupancy  (out_occupancy),
    .out_free_slots (out_free_slots),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_capacity   (cfg_capacity)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Monitor. Everything is sampled at the rising edge, before the nonblocking
  // updates of that edge land, so the values seen are the ones the uut saw.
  // Result words are checked before the command of the same edge is noted;
  // a result is always registered after its command is taken, so order holds.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe)
        board.check_word(result_t'({out_data_out, out_data_valid, out_last, out_status,
                                    out_done_count, out_occupancy, out_free_slots}));
      if (cfg_valid && cfg_ready)
        board.set_capacity(cfg_capacity);
      if (start && !busy)
        board.predict_command(in_kind, in_data_byte, in_count);
    end
  end

  // Present one command and hold it until the uut takes it. start stays high
  // into the next call unless the sender decides to idle first.
  task automatic send_cmd(logic [2:0] kind, logic [7:0] b, logic [6:0] cnt);
    start        <= 1'b1;
    in_kind      <= kind;
    in_data_byte <= b;
    in_count     <= cnt;
    do @(posedge clk); while (busy);
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // Stop sending and wait for every owed word; anything still owed after the
  // limit counts as a failure and is dropped. The first edge lets the monitor
  // note a command taken at the edge this task was called on.
  task automatic drain_results();
    int waited;
    waited = 0;
    start <= 1'b0;
    @(posedge clk);
    while (board.pending() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    while (board.pending() > 0) begin
      board.report("result word never arrived");
      void'(board.owed_words.pop_front());
    end
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Capacity writes happen only with the queue idle (called after reset or a drain).
  task automatic write_capacity(logic [10:0] v);
    cfg_valid    <= 1'b1;
    cfg_capacity <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly small runs; occasionally zero, mid-size, or past the saturation point.
  function automatic logic [6:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 7'd0;
    if (r < 85) return 7'($urandom_range(1, 8));
    if (r < 93) return 7'($urandom_range(9, 63));
    return 7'($urandom_range(64, 127));
  endfunction

  // Push-heavy so small rings fill up and wrap; spare kinds now and then.
  function automatic logic [2:0] pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return brf_pkg::KIND_PUSH;
    if (r < 65) return brf_pkg::KIND_POP;
    if (r < 75) return brf_pkg::KIND_PEEK;
    if (r < 85) return brf_pkg::KIND_DISCARD;
    if (r < 88) return brf_pkg::KIND_CLEAR;
    if (r < 96) return brf_pkg::KIND_STATUS;
    return (r < 98) ? KIND_SPARE6 : KIND_SPARE7;
  endfunction

  task automatic run_phase(int idle_pct, logic [10:0] capv, int n_items);
    sender_idle_pct = idle_pct;
    write_capacity(capv);
    for (int i = 0; i < n_items; i++) begin
      send_cmd(pick_kind(), 8'($urandom_range(0, 255)), pick_count());
      // hold off mid-phase until the uut has delivered everything
      if (i == n_items / 2) drain_results();
    end
    drain_results();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty queue, byte extremes, count zero and saturation, all kinds
    sender_idle_pct = 0;
    write_capacity(11'd1024);
    send_cmd(brf_pkg::KIND_STATUS, 8'h00, 7'd0);
    send_cmd(brf_pkg::KIND_POP, 8'h00, 7'd1);
    send_cmd(brf_pkg::KIND_PEEK, 8'h00, 7'd5);
    send_cmd(brf_pkg::KIND_DISCARD, 8'h00, 7'd3);
    send_cmd(brf_pkg::KIND_PUSH, 8'h00, 7'd0);
    send_cmd(brf_pkg::KIND_PUSH, 8'hFF, 7'd127);
    send_cmd(brf_pkg::KIND_PEEK, 8'h00, 7'd0);
    send_cmd(brf_pkg::KIND_PEEK, 8'h00, 7'd127);
    send_cmd(brf_pkg::KIND_POP, 8'h00, 7'd1);
    send_cmd(brf_pkg::KIND_DISCARD, 8'h00, 7'd64);
    send_cmd(brf_pkg::KIND_CLEAR, 8'h00, 7'd0);
    send_cmd(KIND_SPARE6, 8'hFF, 7'd127);
    send_cmd(KIND_SPARE7, 8'h00, 7'd0);
    send_cmd(brf_pkg::KIND_PUSH, 8'hA5, 7'd0);
    send_cmd(brf_pkg::KIND_POP, 8'h00, 7'd0);
    drain_results();

    // two-slot ring: fill, reject when full, wrap the write index
    write_capacity(11'd2);
    send_cmd(brf_pkg::KIND_PUSH, 8'h5A, 7'd0);
    send_cmd(brf_pkg::KIND_PUSH, 8'h3C, 7'd0);
    send_cmd(brf_pkg::KIND_PUSH, 8'h81, 7'd0);
    send_cmd(brf_pkg::KIND_POP, 8'h00, 7'd1);
    send_cmd(brf_pkg::KIND_PUSH, 8'h7E, 7'd0);
    send_cmd(brf_pkg::KIND_PEEK, 8'h00, 7'd64);
    send_cmd(brf_pkg::KIND_POP, 8'h00, 7'd127);
    drain_results();

    // capacity zero clamps to one slot
    write_capacity(11'd0);
    send_cmd(brf_pkg::KIND_PUSH, 8'hC3, 7'd0);
    send_cmd(brf_pkg::KIND_PUSH, 8'h18, 7'd0);
    send_cmd(brf_pkg::KIND_POP, 8'h00, 7'd2);
    drain_results();

    // random: sender idling 33%, then 58%, then back to back
    run_phase(33, 11'($urandom_range(3, 9)), 32);
    run_phase(58, 11'd2047, 32);
    run_phase(0, 11'($urandom_range(1, 16)), 32);

    drain_results();
    $display("Run covered %0d commands (%0d rejected pushes, %0d bytes popped or peeked)",
             board.commands, board.rejects, board.byte_reads);
    $display("  over %0d capacity settings; %0d result words checked",
             board.cap_writes, board.words_checked);
    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // hard stop: far beyond the slowest correct run
  initial begin
    #3_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
